@@ sv/shared_buffer_multi_queue_macros.svh @@
// ---------------------------------------------------------------------------
// Shared buffer multi-queue assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH

// Same-cycle implication
`define SBMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SBMQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sbmq_pkg.sv @@
// ---------------------------------------------------------------------------
// Shared buffer multi-queue package
// Sizes, codes and store request types shared by the queue manager files.
// ---------------------------------------------------------------------------
`default_nettype none

package sbmq_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned QUEUES     = 4;
  localparam int unsigned DATA_WIDTH = 32;

  // Entry index and link widths; a link holds one extra code for null
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LINK_W = $clog2(ENTRIES + 1);
  localparam int unsigned QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  // Item field widths
  localparam int unsigned QID_W    = 2;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_TDATA_W  = ((QID_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((STATUS_W + VAL_W + 7) / 8) * 8;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ENTRIES);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_e;

  // Write request into the entry store
  typedef struct packed {
    logic                  link_we;
    logic [IDX_W-1:0]      link_addr;
    logic [LINK_W-1:0]     link_data;
    logic                  data_we;
    logic [IDX_W-1:0]      data_addr;
    logic [DATA_WIDTH-1:0] data_data;
  } store_wr_t;

  // Read request into the entry store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } store_rd_t;

endpackage

`default_nettype wire

@@ sv/sbmq_store.sv @@
// ---------------------------------------------------------------------------
// Shared buffer multi-queue entry store
// Link and data memories with registered reads. Links carry a
// per-entry written flag so that an unwritten link reads as its reset chain.
// ---------------------------------------------------------------------------
`default_nettype none

module sbmq_store
  import sbmq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire store_wr_t             wr_i,
  input  wire store_rd_t             rd_i,
  output logic [LINK_W-1:0]          link_o,
  output logic [DATA_WIDTH-1:0]      data_o
);

  logic [LINK_W-1:0]     link_mem [ENTRIES];
  logic [DATA_WIDTH-1:0] data_mem [ENTRIES];

  logic [ENTRIES-1:0]    link_vld_q;
  logic [LINK_W-1:0]     link_rdata_q;
  logic [DATA_WIDTH-1:0] data_rdata_q;
  logic [IDX_W-1:0]      rd_addr_q;

  // Write ports and registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_i.link_we) begin
      link_mem[wr_i.link_addr] <= wr_i.link_data;
    end
    if (wr_i.data_we) begin
      data_mem[wr_i.data_addr] <= wr_i.data_data;
    end
    if (rd_i.en) begin
      link_rdata_q <= link_mem[rd_i.addr];
      data_rdata_q <= data_mem[rd_i.addr];
      rd_addr_q    <= rd_i.addr;
    end
  end

  // Mark links once written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (wr_i.link_we) begin
      link_vld_q[wr_i.link_addr] <= 1'b1;
    end
  end

  // Unwritten entry i links to i+1; the last one thereby reads as null
  assign link_o = link_vld_q[rd_addr_q] ? link_rdata_q
                                        : LINK_W'(rd_addr_q) + LINK_W'(1);
  assign data_o = data_rdata_q;

endmodule

`default_nettype wire

@@ sv/shared_buffer_multi_queue.sv @@
// Ordering: a result item is registered on the output once its input item is
// accepted and S_EXEC runs, later while the previous result item still waits.
// Flow: a new item is taken only in S_IDLE, after the last one is done; each
// item reads the link memory in its accept cycle, writes the link back in S_EXEC.
// Reset: all queues empty and the free list runs through the entries in order;
// no clearing pass, items are taken from the first cycle after reset.
// ---------------------------------------------------------------------------
// Shared buffer multi-queue
// Several FIFO queues kept as linked chains in one shared entry store, with
// a free list of unused entries. Enqueue and dequeue report a status code.
// ---------------------------------------------------------------------------
`default_nettype none

`include "shared_buffer_multi_queue_macros.svh"

module shared_buffer_multi_queue
  import sbmq_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [1:0] queue_id, [33:2] value, upper bits zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [1:0] status, [33:2] data, upper bits zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  fsm_e state_q, state_d;

  // Latched item
  op_e              op_q;
  logic [QID_W-1:0] qid_q;
  logic [VAL_W-1:0] val_q;

  // Queue pointers and free list head
  logic [LINK_W-1:0] head_q [QUEUES];
  logic [IDX_W-1:0]  tail_q [QUEUES];
  logic [LINK_W-1:0] free_q, free_d;

  // Output register
  logic                m_tvalid_q;
  status_e             status_q, status_d;
  logic [VAL_W-1:0]    data_q, data_d;

  logic                in_fire;
  op_e                 in_op;
  logic [QIDX_W-1:0]   in_qidx;
  logic [QIDX_W-1:0]   qidx;
  logic                q_ok;
  logic                exec_go;
  logic                enq_ok;
  logic [LINK_W-1:0]   cur_head;
  logic [IDX_W-1:0]    cur_tail;
  logic                head_we, tail_we;
  logic [LINK_W-1:0]   head_wdata;
  logic [IDX_W-1:0]    tail_wdata;
  logic [LINK_W-1:0]   st_link;
  logic [DATA_WIDTH-1:0] st_data;
  store_wr_t           st_wr;
  store_rd_t           st_rd;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_op         = op_e'(s_axis_tuser);
  assign in_qidx       = QIDX_W'(s_axis_tdata[QID_W-1:0]);

  // Read the link and data of the entry this item will touch
  always_comb begin
    st_rd.en   = in_fire;
    st_rd.addr = (in_op == OP_DEQ) ? IDX_W'(head_q[in_qidx]) : IDX_W'(free_q);
  end

  sbmq_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (st_wr),
    .rd_i   (st_rd),
    .link_o (st_link),
    .data_o (st_data)
  );

  // Sequencer: accept, then update once the output register is free
  assign exec_go = (state_q == S_EXEC) && (!m_tvalid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_op;
      qid_q <= s_axis_tdata[QID_W-1:0];
      val_q <= s_axis_tdata[QID_W +: VAL_W];
    end
  end

  assign qidx     = QIDX_W'(qid_q);
  assign q_ok     = (int'(qid_q) < int'(QUEUES));
  assign cur_head = head_q[qidx];
  assign cur_tail = tail_q[qidx];

  // Modify queue pointers, free list and links
  always_comb begin
    free_d     = free_q;
    status_d   = ST_OK;
    data_d     = '0;
    head_we    = 1'b0;
    head_wdata = cur_head;
    tail_we    = 1'b0;
    tail_wdata = cur_tail;
    enq_ok     = 1'b0;
    st_wr      = '0;
    st_wr.data_addr = IDX_W'(free_q);
    st_wr.data_data = DATA_WIDTH'(val_q);
    if (op_q == OP_ENQ) begin
      enq_ok = q_ok && (free_q != NIL_LINK);
      if (!enq_ok) begin
        status_d = ST_FULL;
      end else if (exec_go) begin
        // Take the free head and link it behind the tail
        free_d        = st_link;
        st_wr.data_we = 1'b1;
        tail_we       = 1'b1;
        tail_wdata    = IDX_W'(free_q);
        if (cur_head == NIL_LINK) begin
          head_we    = 1'b1;
          head_wdata = free_q;
        end else begin
          st_wr.link_we   = 1'b1;
          st_wr.link_addr = cur_tail;
          st_wr.link_data = free_q;
        end
      end
    end else begin
      if (!q_ok || (cur_head == NIL_LINK)) begin
        status_d = ST_EMPTY;
      end else begin
        data_d = VAL_W'($signed(st_data));
        if (exec_go) begin
          // Unlink the head; the tail entry ends its queue
          head_we    = 1'b1;
          head_wdata = (IDX_W'(cur_head) == cur_tail) ? NIL_LINK : st_link;
          st_wr.link_we   = 1'b1;
          st_wr.link_addr = IDX_W'(cur_head);
          st_wr.link_data = free_q;
          free_d          = cur_head;
        end
      end
    end
  end

  // Heads and free list head reset to the empty state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(QUEUES); i++) begin
        head_q[i] <= NIL_LINK;
      end
      free_q <= '0;
    end else begin
      if (head_we) begin
        head_q[qidx] <= head_wdata;
      end
      free_q <= free_d;
    end
  end

  // Tails are only read once written
  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_q[qidx] <= tail_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (exec_go) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      status_q <= status_d;
      data_q   <= data_d;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({data_q, status_q});

  `SBMQ_ASSERT_NXT(a_fire_to_exec, in_fire, state_q == S_EXEC, "accepted item did not start")
  `SBMQ_ASSERT_NXT(a_exec_holds, (state_q == S_EXEC) && m_tvalid_q && !m_axis_tready,
                   state_q == S_EXEC, "update ran while result register was full")
  `SBMQ_ASSERT_IMP(a_fail_zero, m_tvalid_q && (status_q != ST_OK), data_q == '0,
                   "failed operation returned nonzero data")
  `SBMQ_ASSERT_NXT(a_enq_moves_free, exec_go && (op_q == OP_ENQ) && enq_ok,
                   free_q != $past(free_q), "enqueue did not advance the free list")

endmodule

`default_nettype wire
